### hw/rtl/oaht_pkg.sv
// Shared types, sizes and codes for the open addressing hash table.
`timescale 1ns / 1ps

package oaht_pkg;

    // Table geometry. The slot count is a power of two, so the hash and the
    // probe wrap reduce to masking the low bits.
    localparam int SLOT_W     = 4;
    localparam int SLOTS      = 2 ** SLOT_W;
    localparam int CNT_W      = SLOT_W + 1;
    localparam int KEY_BYTES  = 8;
    localparam int KB_W       = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    // Field widths of the request and result.
    localparam int OP_W       = 2;
    localparam int KEY_W      = 64;
    localparam int AGE_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int MARK_W     = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Slot marks.
    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age_in;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [AGE_W-1:0]      age_out;
        logic [SLOT_OUT_W-1:0] slot_out;
    } t_res;

    // One stored table entry.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
    } t_entry;

    // Hash unit answer: normalized key and home slot.
    typedef struct packed {
        logic [KEY_W-1:0]  norm;
        logic [SLOT_W-1:0] home;
    } t_hash_res;

endpackage

### hw/rtl/open_addressing_hash_table.sv
// Top level: linear probing hash table with tombstones and its probe sequencer.
`timescale 1ns / 1ps

// A request (insert, lookup or delete) is presented on i_req and taken at a
// rising edge where start is high and busy is low. busy stays high while the
// request is worked on; one request is in flight at a time.
// The key is first hashed one byte per cycle, up to the first zero byte and
// at most 8 bytes. The table is then probed from the home slot one slot at a
// time; for a lookup or delete, a used slot also passes through a compare
// state, since the stored key comes out of the entry RAM registered after its
// address. The hash result is handed over to the probe in the hash state.
// The result appears on o_res for exactly one cycle with o_res_valid high;
// the receiver cannot hold it off. busy falls in that same cycle, so the
// next request may be taken while the result is shown.
// Synchronous reset marks every slot empty and idles the block.

module open_addressing_hash_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  oaht_pkg::t_req i_req,
    output logic           busy,
    output logic           o_res_valid,
    output oaht_pkg::t_res o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_CMP
    } t_state;

    t_state                          r_state;
    logic [oaht_pkg::OP_W-1:0]       r_op;
    logic [oaht_pkg::AGE_W-1:0]      r_age;
    logic [oaht_pkg::KEY_W-1:0]      r_key;
    logic [oaht_pkg::SLOT_W-1:0]     r_slot;
    logic [oaht_pkg::CNT_W-1:0]      r_cnt;
    logic [oaht_pkg::MARK_W-1:0]     r_marks [oaht_pkg::SLOTS];
    logic                            r_res_valid;
    oaht_pkg::t_res                  r_res;

    logic                            accept;
    logic                            hash_done;
    oaht_pkg::t_hash_res             hash_res;
    logic [oaht_pkg::MARK_W-1:0]     cur_mark;
    logic                            probes_left;
    logic                            ins_here;
    logic                            ram_we;
    oaht_pkg::t_entry                wr_entry;
    logic [$bits(oaht_pkg::t_entry)-1:0] rd_bits;
    oaht_pkg::t_entry                rd_entry;
    logic                            key_match;
    logic [oaht_pkg::STATUS_W-1:0]   fail_status;

    assign accept = start && !busy;

    // Key hash unit.
    oaht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_key   (i_req.key),
        .o_done  (hash_done),
        .o_res   (hash_res)
    );

    // Probe decode: current mark, insert slot found, key compare.
    always_comb begin
        cur_mark     = r_marks[r_slot];
        probes_left  = (r_cnt != oaht_pkg::CNT_W'(oaht_pkg::SLOTS));
        ins_here     = (cur_mark == oaht_pkg::MARK_EMPTY)
                    || (cur_mark == oaht_pkg::MARK_DELETED);
        ram_we       = (r_state == S_PROBE) && probes_left
                    && (r_op == oaht_pkg::OP_INSERT) && ins_here;
        wr_entry.key = r_key;
        wr_entry.age = r_age;
        rd_entry     = oaht_pkg::t_entry'(rd_bits);
        key_match    = (rd_entry.key == r_key);
        fail_status  = (r_op == oaht_pkg::OP_INSERT) ? oaht_pkg::ST_FULL
                                                     : oaht_pkg::ST_NOT_FOUND;
    end

    // Key and age store, addressed by the probe slot.
    oaht_ram #(
        .WIDTH ($bits(oaht_pkg::t_entry)),
        .DEPTH (oaht_pkg::SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (wr_entry),
        .i_raddr (r_slot),
        .o_rdata (rd_bits)
    );

    // Request sequencer, slot marks and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_cnt       <= '0;
            for (int i = 0; i < oaht_pkg::SLOTS; i++) begin
                r_marks[i] <= oaht_pkg::MARK_EMPTY;
            end
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_req.op;
                        r_age   <= i_req.age_in;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_key   <= hash_res.norm;
                        r_slot  <= hash_res.home;
                        r_cnt   <= '0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (!probes_left) begin
                        r_res.status   <= fail_status;
                        r_res.age_out  <= '0;
                        r_res.slot_out <= '0;
                        r_res_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end else begin
                        unique case (r_op) inside
                            oaht_pkg::OP_INSERT: begin
                                if (ins_here) begin
                                    r_marks[r_slot] <= oaht_pkg::MARK_USED;
                                    r_res.status    <= oaht_pkg::ST_OK;
                                    r_res.age_out   <= '0;
                                    r_res.slot_out  <= oaht_pkg::SLOT_OUT_W'(r_slot);
                                    r_res_valid     <= 1'b1;
                                    r_state         <= S_IDLE;
                                end else begin
                                    r_slot <= r_slot + 1'b1;
                                    r_cnt  <= r_cnt + 1'b1;
                                end
                            end
                            oaht_pkg::OP_LOOKUP, oaht_pkg::OP_DELETE: begin
                                if (cur_mark == oaht_pkg::MARK_EMPTY) begin
                                    r_res.status   <= oaht_pkg::ST_NOT_FOUND;
                                    r_res.age_out  <= '0;
                                    r_res.slot_out <= '0;
                                    r_res_valid    <= 1'b1;
                                    r_state        <= S_IDLE;
                                end else if (cur_mark == oaht_pkg::MARK_DELETED) begin
                                    r_slot <= r_slot + 1'b1;
                                    r_cnt  <= r_cnt + 1'b1;
                                end else begin
                                    r_state <= S_CMP;
                                end
                            end
                            default: begin
                                r_res.status   <= oaht_pkg::ST_NOT_FOUND;
                                r_res.age_out  <= '0;
                                r_res.slot_out <= '0;
                                r_res_valid    <= 1'b1;
                                r_state        <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CMP: begin
                    if (key_match) begin
                        if (r_op == oaht_pkg::OP_DELETE) begin
                            r_marks[r_slot] <= oaht_pkg::MARK_DELETED;
                        end
                        r_res.status   <= oaht_pkg::ST_OK;
                        r_res.age_out  <= rd_entry.age;
                        r_res.slot_out <= oaht_pkg::SLOT_OUT_W'(r_slot);
                        r_res_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_PROBE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request accepted but block not busy");

    // A result is only shown once the sequencer is back at rest.
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result shown while busy");

    // A full table can only be reported for an insert.
    a_full_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == oaht_pkg::ST_FULL))
            |-> (r_op == oaht_pkg::OP_INSERT))
        else $error("table full reported for a non-insert request");

    // Failed requests carry zero age and slot.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != oaht_pkg::ST_OK))
            |-> ((o_res.age_out == '0) && (o_res.slot_out == '0)))
        else $error("failed request with nonzero age or slot");

    // The probe never visits more slots than the table holds.
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_cnt < oaht_pkg::CNT_W'(oaht_pkg::SLOTS)))
        else $error("probe count past the slot count");

endmodule

### hw/rtl/oaht_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/oaht_hash.sv
// Iterative key hash: one key byte per cycle through a shared add and multiply.
`timescale 1ns / 1ps

module oaht_hash (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [oaht_pkg::KEY_W-1:0]  i_key,
    output logic                        o_done,
    output oaht_pkg::t_hash_res         o_res
);

    logic                         r_run;
    logic                         r_done;
    logic [oaht_pkg::KB_W-1:0]    r_idx;
    logic [oaht_pkg::KEY_W-1:0]   r_key;
    logic [oaht_pkg::KEY_W-1:0]   r_norm;
    logic [oaht_pkg::SLOT_W-1:0]  r_h;

    logic [7:0]                   cur_byte;
    logic [oaht_pkg::SLOT_W-1:0]  sum;
    logic [oaht_pkg::SLOT_W-1:0]  n_h;
    logic                         last_byte;

    // Shared step: h = (h + b) * b, kept to the slot bits.
    always_comb begin
        cur_byte  = r_key[7:0];
        sum       = r_h + cur_byte[oaht_pkg::SLOT_W-1:0];
        n_h       = oaht_pkg::SLOT_W'(sum * cur_byte[oaht_pkg::SLOT_W-1:0]);
        last_byte = (r_idx == oaht_pkg::KB_W'(oaht_pkg::KEY_BYTES - 1));
    end

    // Byte sequencer; the key shifts down one byte per step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_run  <= 1'b1;
                r_idx  <= '0;
                r_key  <= i_key;
                r_norm <= '0;
                r_h    <= '0;
            end else if (r_run) begin
                if (cur_byte == 8'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_h                 <= n_h;
                    r_norm[r_idx*8 +: 8] <= cur_byte;
                    r_key               <= r_key >> 8;
                    r_idx               <= r_idx + 1'b1;
                    if (last_byte) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_res.norm = r_norm;
    assign o_res.home = r_h;

endmodule
